### rtl/core/ibls_pkg.sv
// Shared constants and types for the iterated binomial line smoother.
package ibls_pkg;

  // Default cascade depth and sample width.
  localparam int MAX_PASSES_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // Pass count register layout and its value after reset.
  localparam int PASS_COUNT_BITS  = 5;
  localparam int PASS_COUNT_RESET = 2;

  // Handshake and framing flags that travel with each word between cells.
  typedef struct packed {
    logic valid;
    logic last;
  } word_ctl_t;

endpackage

### rtl/core/ibls_cell.sv
// One smoothing stage of the cascade: a [1,2,1]/4 filter with edge replication.
module ibls_cell #(
  parameter int SAMPLE_BITS = ibls_pkg::SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    active,
  input  logic                    clear,
  input  ibls_pkg::word_ctl_t     in_ctl,
  input  logic [SAMPLE_BITS-1:0]  in_sample,
  output logic                    in_stall,
  output ibls_pkg::word_ctl_t     out_ctl,
  output logic [SAMPLE_BITS-1:0]  out_sample,
  input  logic                    out_stall
);

  // Rounded (a + 2b + c + 2) >> 2; the sum is two bits wider, so it cannot overflow.
  function automatic logic [SAMPLE_BITS-1:0] smooth3(
    input logic [SAMPLE_BITS-1:0] a,
    input logic [SAMPLE_BITS-1:0] b,
    input logic [SAMPLE_BITS-1:0] c
  );
    logic [SAMPLE_BITS+1:0] sum;
    sum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + (SAMPLE_BITS+2)'(2);
    return sum[SAMPLE_BITS+1:2];
  endfunction

  logic [SAMPLE_BITS-1:0] prev, prev_next;
  logic [SAMPLE_BITS-1:0] cur, cur_next;
  logic                   filled, filled_next;
  logic                   pend, pend_next;
  logic                   out_valid, out_valid_next;
  logic                   out_last, out_last_next;
  logic [SAMPLE_BITS-1:0] out_data, out_data_next;

  logic                   out_free;
  logic                   take;
  logic [SAMPLE_BITS-1:0] smooth_in;
  logic [SAMPLE_BITS-1:0] smooth_flush;

  // The output register frees up when empty or when its word leaves this cycle.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = pend || !out_free;
  assign take     = in_ctl.valid && !in_stall;

  assign smooth_in    = smooth3(prev, cur, in_sample);
  assign smooth_flush = smooth3(prev, cur, cur);

  // Next state of the stage and its output register.
  always_comb begin
    prev_next      = prev;
    cur_next       = cur;
    filled_next    = filled;
    pend_next      = pend;
    out_valid_next = out_valid && out_stall;
    out_last_next  = out_last;
    out_data_next  = out_data;

    if (pend && out_free) begin
      // Line end flush: the last sample's right neighbor is itself.
      out_valid_next = 1'b1;
      out_data_next  = smooth_flush;
      out_last_next  = 1'b1;
      pend_next      = 1'b0;
      filled_next    = 1'b0;
    end else if (take) begin
      if (!active) begin
        // Stage not in use: the word goes through unchanged.
        out_valid_next = 1'b1;
        out_data_next  = in_sample;
        out_last_next  = in_ctl.last;
      end else if (!filled) begin
        // First sample of a line; a one-sample line comes out as it is.
        prev_next = in_sample;
        cur_next  = in_sample;
        if (in_ctl.last) begin
          out_valid_next = 1'b1;
          out_data_next  = in_sample;
          out_last_next  = 1'b1;
        end else begin
          filled_next = 1'b1;
        end
      end else begin
        // The held sample now has its right neighbor.
        out_valid_next = 1'b1;
        out_data_next  = smooth_in;
        out_last_next  = 1'b0;
        prev_next      = cur;
        cur_next       = in_sample;
        pend_next      = in_ctl.last;
      end
    end

    if (clear) begin
      filled_next = 1'b0;
      pend_next   = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      filled    <= filled_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  // Sample history and output payload.
  always_ff @(posedge clk) begin
    prev     <= prev_next;
    cur      <= cur_next;
    out_last <= out_last_next;
    out_data <= out_data_next;
  end

  assign out_ctl.valid = out_valid;
  assign out_ctl.last  = out_last;
  assign out_sample    = out_data;

endmodule

### rtl/core/iterated_binomial_line_smoother.sv
// Path: an accepted word passes the output register of every stage, active or not, plus one
// word of delay per active pass while a stage waits for the right neighbor.
// Throughput: one word per cycle while the output does not stall; each active stage stalls
// its own input while it flushes the held sample at the end of a line of two or more words,
// while the later stages flush as the stage ahead takes a new line. Reset: synchronous;
// stages empty, pass_count 2. A pass_count write drops the partial line held in every stage.
module iterated_binomial_line_smoother #(
  parameter int MAX_PASSES  = ibls_pkg::MAX_PASSES_DEF,
  parameter int SAMPLE_BITS = ibls_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [SAMPLE_BITS-1:0]               sample_in,
  input  logic                                 line_end_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [SAMPLE_BITS-1:0]               sample_out,
  output logic                                 line_end_out,
  input  logic                                 cfg_wr_en,
  input  logic [ibls_pkg::PASS_COUNT_BITS-1:0] cfg_wr_data
);

  localparam int PASS_BITS  = $clog2(MAX_PASSES + 1);
  localparam int PASS_RESET = (ibls_pkg::PASS_COUNT_RESET > MAX_PASSES) ?
                              MAX_PASSES : ibls_pkg::PASS_COUNT_RESET;

  logic [PASS_BITS-1:0]   passes, passes_next;
  logic [MAX_PASSES-1:0]  cell_active;

  ibls_pkg::word_ctl_t    chain_ctl    [MAX_PASSES+1];
  logic [SAMPLE_BITS-1:0] chain_sample [MAX_PASSES+1];
  logic                   chain_stall  [MAX_PASSES+1];

  // Written pass count saturates at the cascade depth.
  always_comb begin
    if ({1'b0, cfg_wr_data} > 6'(MAX_PASSES)) begin
      passes_next = PASS_BITS'(MAX_PASSES);
    end else begin
      passes_next = PASS_BITS'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      passes <= PASS_BITS'(PASS_RESET);
    end else if (cfg_wr_en) begin
      passes <= passes_next;
    end
  end

  // Input word enters the first cell.
  assign chain_ctl[0].valid = in_valid;
  assign chain_ctl[0].last  = line_end_in;
  assign chain_sample[0]    = sample_in;
  assign in_stall           = chain_stall[0];

  // Cascade of stages; stages at or beyond the pass count pass words through.
  for (genvar k = 0; k < MAX_PASSES; k++) begin : g_cell
    assign cell_active[k] = (passes > PASS_BITS'(k));

    ibls_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .active    (cell_active[k]),
      .clear     (cfg_wr_en),
      .in_ctl    (chain_ctl[k]),
      .in_sample (chain_sample[k]),
      .in_stall  (chain_stall[k]),
      .out_ctl   (chain_ctl[k+1]),
      .out_sample(chain_sample[k+1]),
      .out_stall (chain_stall[k+1])
    );
  end

  // Last cell drives the output channel.
  assign chain_stall[MAX_PASSES] = out_stall;
  assign out_valid               = chain_ctl[MAX_PASSES].valid;
  assign line_end_out            = chain_ctl[MAX_PASSES].last;
  assign sample_out              = chain_sample[MAX_PASSES];

endmodule

### tb/tb.sv
// Self-checking testbench for the iterated binomial line smoother.
module tb;

  localparam int PASSES_MAX  = ibls_pkg::MAX_PASSES_DEF;
  localparam int SBITS       = ibls_pkg::SAMPLE_BITS_DEF;
  localparam int SETTLE      = PASSES_MAX + 24;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int WORDS_PHASE = 56;

  typedef struct packed {
    logic [SBITS-1:0] sample;
    logic             last;
  } line_word_t;

  logic                                 clk;
  logic                                 rst         = 1'b1;
  logic                                 in_valid    = 1'b0;
  logic                                 in_stall;
  logic [SBITS-1:0]                     sample_in   = '0;
  logic                                 line_end_in = 1'b0;
  logic                                 out_valid;
  logic                                 out_stall   = 1'b0;
  logic [SBITS-1:0]                     sample_out;
  logic                                 line_end_out;
  logic                                 cfg_wr_en   = 1'b0;
  logic [ibls_pkg::PASS_COUNT_BITS-1:0] cfg_wr_data = '0;

  iterated_binomial_line_smoother dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .line_end_in  (line_end_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out),
    .line_end_out (line_end_out),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // Words waiting to be sent and smoothed words still to arrive.
  line_word_t pending_words[$];
  line_word_t smoothed_words[$];
  line_word_t offered;
  line_word_t want;

  // Shadow copy of the cascade state and the pass count.
  logic [ibls_pkg::PASS_COUNT_BITS-1:0] pass_setting;
  logic [SBITS-1:0]                     stage_prev [PASSES_MAX];
  logic [SBITS-1:0]                     stage_held [PASSES_MAX];
  logic [1:0]                           stage_fill [PASSES_MAX];

  logic steady   = 1'b0;
  logic hold_req = 1'b0;
  bit   hold_done;
  int   hold_left;
  int   errors;
  int   cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Rounded [1,2,1]/4 kernel; the 18-bit sum cannot overflow.
  function automatic logic [SBITS-1:0] binomial3(logic [SBITS-1:0] a, logic [SBITS-1:0] b,
                                                 logic [SBITS-1:0] c);
    logic [SBITS+1:0] sum;
    sum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + (SBITS+2)'(2);
    return sum[SBITS+1:2];
  endfunction

  function automatic void clear_stages();
    for (int k = 0; k < PASSES_MAX; k++) begin
      stage_prev[k] = '0;
      stage_held[k] = '0;
      stage_fill[k] = 2'd0;
    end
  endfunction

  // Push one accepted word through every active stage and queue what comes out.
  function automatic void smooth_cascade(line_word_t w);
    line_word_t stage_in[$];
    line_word_t stage_out[$];
    int         active;
    active = (pass_setting > PASSES_MAX) ? PASSES_MAX : int'(pass_setting);
    stage_in.insert(stage_in.size(), w);
    for (int k = 0; k < active; k++) begin
      stage_out.delete();
      foreach (stage_in[i]) begin
        if (stage_fill[k] == 2'd0) begin
          stage_prev[k] = stage_in[i].sample;
          stage_held[k] = stage_in[i].sample;
          stage_fill[k] = 2'd1;
        end else begin
          stage_out.insert(stage_out.size(),
                           line_word_t'{binomial3(stage_prev[k], stage_held[k],
                                                  stage_in[i].sample), 1'b0});
          stage_prev[k] = stage_held[k];
          stage_held[k] = stage_in[i].sample;
          stage_fill[k] = 2'd2;
        end
        // The line end flushes the held sample with itself as right neighbor.
        if (stage_in[i].last) begin
          stage_out.insert(stage_out.size(),
                           line_word_t'{binomial3(stage_prev[k], stage_held[k],
                                                  stage_held[k]), 1'b1});
          stage_fill[k] = 2'd0;
        end
      end
      stage_in = stage_out;
    end
    foreach (stage_in[i]) smoothed_words.insert(smoothed_words.size(), stage_in[i]);
  endfunction

  function automatic void push_word(logic [SBITS-1:0] s, logic l);
    pending_words.insert(pending_words.size(), line_word_t'{s, l});
  endfunction

  // Random lines, mostly short, now and then long, with edge values favored.
  task automatic push_random_lines(int count);
    int added;
    int len;
    int pick;
    logic [SBITS-1:0] s;
    added = 0;
    while (added < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(7);
        s = (pick == 0) ? '0 : (pick == 1) ? '1 : SBITS'($urandom_range(65535));
        push_word(s, i == len - 1);
      end
      added += len;
    end
  endtask

  // Wait until every word is sent and every result is in, then let the pipe settle.
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || smoothed_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // A pass count write also drops the partial line held in every stage.
  task automatic set_passes(logic [ibls_pkg::PASS_COUNT_BITS-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    pass_setting = v;
    clear_stages();
  endtask

  // Driver: offer the next pending word, holding it while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) smooth_cascade(offered);
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && (steady || $urandom_range(99) >= 10)) begin
          offered = pending_words.pop_front();
          in_valid    <= 1'b1;
          sample_in   <= offered.sample;
          line_end_in <= offered.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted word against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (smoothed_words.size() == 0) begin
          if (errors < 10)
            $display("unexpected word: sample %h line_end %b", sample_out, line_end_out);
          errors++;
        end else begin
          want = smoothed_words.pop_front();
          if (sample_out !== want.sample || line_end_out !== want.last) begin
            if (errors < 10)
              $display("mismatch: sample exp %h got %h, line_end exp %b got %b",
                       want.sample, sample_out, want.last, line_end_out);
            errors++;
          end
        end
      end
      // One long hold-off so the cascade backs up into the input.
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 10);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus: directed lines at the reset pass count, then one phase per setting.
  initial begin
    int plan[7];
    plan = '{0, 1, 16, 31, 7, 0, 15};
    pass_setting = ibls_pkg::PASS_COUNT_BITS'(ibls_pkg::PASS_COUNT_RESET);
    clear_stages();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-sample lines at both extremes, then short lines and rounding cases.
    push_word('0, 1'b1);
    push_word('1, 1'b1);
    push_word('0, 1'b0);
    push_word('1, 1'b1);
    push_word('1, 1'b0);
    push_word('1, 1'b0);
    push_word('1, 1'b1);
    push_word('1, 1'b0);
    push_word('0, 1'b0);
    push_word('1, 1'b0);
    push_word('0, 1'b0);
    push_word('1, 1'b1);
    push_word(16'd1, 1'b0);
    push_word(16'd0, 1'b0);
    push_word(16'd0, 1'b0);
    push_word(16'd2, 1'b1);
    for (int i = 1; i <= 6; i++) push_word(SBITS'(i), i == 6);

    for (int p = 0; p < 7; p++) begin
      wait_idle();
      set_passes((p == 5) ? ibls_pkg::PASS_COUNT_BITS'($urandom_range(31)) :
                            ibls_pkg::PASS_COUNT_BITS'(plan[p]));
      steady <= (p == 1);
      push_random_lines(WORDS_PHASE);
      if (p == 2) hold_req <= 1'b1;
      // Leave a line open so the next pass count write drops it.
      if (p == 4) begin
        push_word(SBITS'($urandom_range(65535)), 1'b0);
        push_word(SBITS'($urandom_range(65535)), 1'b0);
        push_word(SBITS'($urandom_range(65535)), 1'b0);
      end
    end
    wait_idle();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
